// ===== rtl/gfpd_pkg.sv =====
// gfpd_pkg: shared types, state codes and constant tables for the gamepad frame decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gfpd_pkg;

	localparam int unsigned TabDepth = 45;
	localparam int unsigned StepW = 6;
	localparam logic [63:0] PiQ56 = 64'h0324_3F6A_8885_A308;
	localparam logic [63:0] QOne = 64'h0100_0000_0000_0000;

	localparam logic [1:0] REG_HEADER = 2'd0;
	localparam logic [1:0] REG_LEFT_DZ = 2'd1;
	localparam logic [1:0] REG_RIGHT_DZ = 2'd2;

	localparam logic [5:0] LAST_STEP = 6'd44;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_LX,
		ST_LY,
		ST_RX,
		ST_RY,
		ST_BL,
		ST_BH,
		ST_CALC,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic ld_lx;
		logic ld_ly;
		logic ld_rx;
		logic ld_ry;
		logic ld_bl;
		logic start;
		logic step;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic hdr_match;
		logic last_step;
	} status_t;

	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[119:56];
	endfunction

	function automatic logic [63:0] sin_div(input logic [63:0] v, input int n);
		logic [63:0] r;
		unique case (n)
			0: r = v / 64'd6;
			1: r = v / 64'd20;
			2: r = v / 64'd42;
			3: r = v / 64'd72;
			4: r = v / 64'd110;
			5: r = v / 64'd156;
			6: r = v / 64'd210;
			7: r = v / 64'd272;
			8: r = v / 64'd342;
			9: r = v / 64'd420;
			10: r = v / 64'd506;
			11: r = v / 64'd600;
			12: r = v / 64'd702;
			default: r = v / 64'd812;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] cos_div(input logic [63:0] v, input int n);
		logic [63:0] r;
		unique case (n)
			0: r = v / 64'd2;
			1: r = v / 64'd12;
			2: r = v / 64'd30;
			3: r = v / 64'd56;
			4: r = v / 64'd90;
			5: r = v / 64'd132;
			6: r = v / 64'd182;
			7: r = v / 64'd240;
			8: r = v / 64'd306;
			9: r = v / 64'd380;
			10: r = v / 64'd462;
			11: r = v / 64'd552;
			12: r = v / 64'd650;
			default: r = v / 64'd756;
		endcase
		return r;
	endfunction

	// sine (sel) or cosine of the half-degree boundaries, series in q56
	function automatic logic [TabDepth-1:0][63:0] build_tab(input logic sel);
		logic [TabDepth-1:0][63:0] tab;
		logic [63:0] t, t2, ts, tc, ss, cc;
		logic [63:0] odd;
		for (int k = 0; k < TabDepth; k++) begin
			odd = 64'(2 * k + 1);
			t = (odd * (PiQ56 / 64'd8)) / 64'd45;
			t2 = mulq(t, t);
			ts = t;
			tc = QOne;
			ss = 64'd0;
			cc = 64'd0;
			for (int n = 0; n < 14; n++) begin
				if (n % 2 == 1) begin
					ss = ss - ts;
					cc = cc - tc;
				end else begin
					ss = ss + ts;
					cc = cc + tc;
				end
				ts = sin_div(mulq(ts, t2), n);
				tc = cos_div(mulq(tc, t2), n);
			end
			tab[k] = sel ? ss : cc;
		end
		return tab;
	endfunction

	localparam logic [TabDepth-1:0][63:0] SIN_TAB = build_tab(1'b1);
	localparam logic [TabDepth-1:0][63:0] COS_TAB = build_tab(1'b0);

endpackage
`default_nettype wire

// ===== rtl/gfpd_stick.sv =====
// gfpd_stick: iterative angle search and bit-serial square root for one stick
// depends on gfpd_pkg
`timescale 1ns / 1ps
`default_nettype none
module gfpd_stick (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic signed [8:0] x,
	input wire logic signed [8:0] y,
	input wire logic start,
	input wire logic step,
	input wire logic [gfpd_pkg::StepW-1:0] step_idx,
	output logic active,
	output logic [9:0] angle,
	output logic [8:0] distance
);
	import gfpd_pkg::*;

	logic [7:0] ax, ay, big, minor;
	logic swap;
	logic [71:0] lhs, rhs;
	logic cmp;
	logic found_q;
	logic [5:0] k_q;
	logic [15:0] n_q;
	logic [7:0] r_q, r_try;
	logic [15:0] r_sq;
	logic signed [17:0] sq_x, sq_y;
	logic [6:0] a;
	logic [8:0] d;
	logic [9:0] e;

	assign ax = x[8] ? 8'(-x) : x[7:0];
	assign ay = y[8] ? 8'(-y) : y[7:0];
	assign swap = ay > ax;
	assign big = swap ? ay : ax;
	assign minor = swap ? ax : ay;
	assign lhs = {64'd0, minor} * {8'd0, COS_TAB[step_idx]};
	assign rhs = {64'd0, big} * {8'd0, SIN_TAB[step_idx]};
	assign cmp = lhs > rhs;
	assign r_try = r_q | (8'h80 >> step_idx[2:0]);
	assign r_sq = {8'd0, r_try} * {8'd0, r_try};
	assign sq_x = x * x;
	assign sq_y = y * y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			k_q <= '0;
			r_q <= '0;
			n_q <= '0;
		end else if (start) begin
			found_q <= 1'b0;
			k_q <= '0;
			r_q <= '0;
			n_q <= 16'(sq_x + sq_y);
		end else if (step) begin
			if (!found_q) begin
				if (cmp) k_q <= step_idx + 6'd1;
				else found_q <= 1'b1;
			end
			if (step_idx < 6'd8 && r_sq <= n_q) r_q <= r_try;
		end
	end

	always_comb begin
		a = swap ? 7'(7'd90 - {1'b0, k_q}) : {1'b0, k_q};
		priority if (!x[8] && !y[8]) d = {2'd0, a};
		else if (x[8] && !y[8]) d = 9'd180 - {2'd0, a};
		else if (x[8]) d = 9'd180 + {2'd0, a};
		else d = 9'd360 - {2'd0, a};
		e = {1'b0, d} + 10'd270;
		if (e >= 10'd360) e = e - 10'd360;
		active = (x != 9'sd0) || (y != 9'sd0);
		angle = active ? e : '1;
		distance = !active ? '1 : (r_q > 8'd128 ? 9'd128 : {1'b0, r_q});
	end
endmodule
`default_nettype wire

// ===== rtl/gfpd_datapath.sv =====
// gfpd_datapath: config registers, frame capture, two stick units and result register
// depends on gfpd_pkg and gfpd_stick
`timescale 1ns / 1ps
`default_nettype none
module gfpd_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic [7:0] data_byte,
	input wire gfpd_pkg::cmd_t cmd,
	output gfpd_pkg::status_t status,
	output logic signed [7:0] left_x,
	output logic signed [8:0] left_y,
	output logic signed [7:0] right_x,
	output logic signed [8:0] right_y,
	output logic left_active,
	output logic signed [9:0] left_angle,
	output logic signed [8:0] left_distance,
	output logic right_active,
	output logic signed [9:0] right_angle,
	output logic signed [8:0] right_distance,
	output logic [15:0] buttons
);
	import gfpd_pkg::*;

	logic [7:0] hdr_q, ldz_q, rdz_q, bl_q, bh_q;
	logic signed [8:0] lx_q, ly_q, rx_q, ry_q;
	logic [5:0] step_q;
	logic signed [8:0] sv, nv;
	logic [8:0] mag;
	logic l_act, r_act;
	logic [9:0] l_ang, r_ang;
	logic [8:0] l_dist, r_dist;

	assign sv = {data_byte[7], data_byte};
	assign nv = -sv;
	assign mag = sv[8] ? 9'(-sv) : sv;
	assign status.hdr_match = data_byte == hdr_q;
	assign status.last_step = step_q == LAST_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			ldz_q <= '0;
			rdz_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
			bl_q <= '0;
			bh_q <= '0;
			step_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_HEADER: hdr_q <= cfg_data;
					REG_LEFT_DZ: ldz_q <= cfg_data;
					REG_RIGHT_DZ: rdz_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.ld_lx) lx_q <= (mag < {1'b0, ldz_q}) ? 9'sd0 : sv;
			if (cmd.ld_ly) ly_q <= (mag < {1'b0, ldz_q}) ? 9'sd0 : nv;
			if (cmd.ld_rx) rx_q <= (mag < {1'b0, rdz_q}) ? 9'sd0 : sv;
			if (cmd.ld_ry) ry_q <= (mag < {1'b0, rdz_q}) ? 9'sd0 : nv;
			if (cmd.ld_bl) bl_q <= data_byte;
			if (cmd.start) begin
				bh_q <= data_byte;
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 6'd1;
			end
		end
	end

	gfpd_stick u_left (
		.clk(clk), .arst_n(arst_n), .x(lx_q), .y(ly_q), .start(cmd.start),
		.step(cmd.step), .step_idx(step_q), .active(l_act), .angle(l_ang),
		.distance(l_dist)
	);

	gfpd_stick u_right (
		.clk(clk), .arst_n(arst_n), .x(rx_q), .y(ry_q), .start(cmd.start),
		.step(cmd.step), .step_idx(step_q), .active(r_act), .angle(r_ang),
		.distance(r_dist)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			left_x <= lx_q[7:0];
			left_y <= ly_q;
			right_x <= rx_q[7:0];
			right_y <= ry_q;
			left_active <= l_act;
			left_angle <= l_ang;
			left_distance <= l_dist;
			right_active <= r_act;
			right_angle <= r_ang;
			right_distance <= r_dist;
			buttons <= {bh_q, bl_q};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gfpd_ctrl.sv =====
// gfpd_ctrl: frame position and calculation sequencing, output valid tracking
// depends on gfpd_pkg
`timescale 1ns / 1ps
`default_nettype none
module gfpd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire gfpd_pkg::status_t status,
	output gfpd_pkg::cmd_t cmd
);
	import gfpd_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q;
	logic accept;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = (state_q == ST_CALC) || (state_q == ST_WAIT);
		accept = in_valid && !in_stall;
		unique case (state_q)
			ST_HUNT: if (accept && status.hdr_match) state_d = ST_LX;
			ST_LX: if (accept) begin
				cmd.ld_lx = 1'b1;
				state_d = ST_LY;
			end
			ST_LY: if (accept) begin
				cmd.ld_ly = 1'b1;
				state_d = ST_RX;
			end
			ST_RX: if (accept) begin
				cmd.ld_rx = 1'b1;
				state_d = ST_RY;
			end
			ST_RY: if (accept) begin
				cmd.ld_ry = 1'b1;
				state_d = ST_BL;
			end
			ST_BL: if (accept) begin
				cmd.ld_bl = 1'b1;
				state_d = ST_BH;
			end
			ST_BH: if (accept) begin
				cmd.start = 1'b1;
				state_d = ST_CALC;
			end
			ST_CALC: begin
				cmd.step = 1'b1;
				if (status.last_step) state_d = ST_WAIT;
			end
			ST_WAIT: if (!out_valid_q || !out_stall) begin
				cmd.ld_out = 1'b1;
				state_d = ST_HUNT;
			end
			default: state_d = ST_HUNT;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/gamepad_frame_polar_decoder_core.sv =====
// gamepad_frame_polar_decoder_core: top level of the gamepad frame decoder
// depends on gfpd_pkg, gfpd_ctrl and gfpd_datapath
`timescale 1ns / 1ps
`default_nettype none
// One received byte per input item. Bytes are dropped until one matches the header
// register, then six frame bytes are taken one per cycle. The last byte starts the
// calculation, set by the half-degree boundary search that runs for both sticks at
// once (the square root uses step indices below 8); the result register is then
// loaded once the output register is free. No byte is taken during that time. A
// finished result waits in the output register while the next frame is collected.
module gamepad_frame_polar_decoder_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [7:0] left_x,
	output logic signed [8:0] left_y,
	output logic signed [7:0] right_x,
	output logic signed [8:0] right_y,
	output logic left_active,
	output logic signed [9:0] left_angle,
	output logic signed [8:0] left_distance,
	output logic right_active,
	output logic signed [9:0] right_angle,
	output logic signed [8:0] right_distance,
	output logic [15:0] buttons
);
	import gfpd_pkg::*;

	cmd_t cmd;
	status_t status;

	gfpd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	gfpd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .data_byte(data_byte), .cmd(cmd), .status(status),
		.left_x(left_x), .left_y(left_y), .right_x(right_x), .right_y(right_y),
		.left_active(left_active), .left_angle(left_angle),
		.left_distance(left_distance), .right_active(right_active),
		.right_angle(right_angle), .right_distance(right_distance),
		.buttons(buttons)
	);
endmodule
`default_nettype wire

// ===== tb/sv/gamepad_frame_polar_decoder_core_tb.sv =====
// gamepad_frame_polar_decoder_core_tb: self-checking testbench for the gamepad frame decoder
// predicts each decoded frame from the byte stream and checks every result item
// depends on gfpd_pkg and gamepad_frame_polar_decoder_core
`timescale 1ns / 1ps
module gamepad_frame_polar_decoder_core_tb;
	import gfpd_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [7:0] lx;
		logic [8:0] ly;
		logic [7:0] rx;
		logic [8:0] ry;
		logic la;
		logic [9:0] lang;
		logic [8:0] ldist;
		logic ra;
		logic [9:0] rang;
		logic [8:0] rdist;
		logic [15:0] btn;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [7:0] left_x, right_x;
	logic signed [8:0] left_y, right_y, left_distance, right_distance;
	logic signed [9:0] left_angle, right_angle;
	logic left_active, right_active;
	logic [15:0] buttons;

	gamepad_frame_polar_decoder_core DUT (.*);

	always #2 clk = ~clk;

	// predictor state
	logic [7:0] hdr_reg, ldz_reg, rdz_reg;
	int frame_pos;
	int hold_lx, hold_ly, hold_rx, hold_ry;
	logic [7:0] hold_bl;
	logic [63:0] bnd_sin [TabDepth];
	logic [63:0] bnd_cos [TabDepth];
	frame_result_t frames_due [$];

	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int hold_len = 0;

	function automatic logic [63:0] q56_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[119:56];
	endfunction

	// sine and cosine at each half-degree boundary, power series in q56
	function automatic void build_boundaries();
		logic [63:0] t, t2, ts, tc, ss, cc;
		for (int k = 0; k < TabDepth; k++) begin
			t = (64'(2 * k + 1) * (PiQ56 / 64'd8)) / 64'd45;
			t2 = q56_mul(t, t);
			ts = t;
			tc = QOne;
			ss = '0;
			cc = '0;
			for (int n = 0; n < 14; n++) begin
				if (n % 2) begin
					ss -= ts;
					cc -= tc;
				end else begin
					ss += ts;
					cc += tc;
				end
				ts = q56_mul(ts, t2) / 64'((2 * n + 2) * (2 * n + 3));
				tc = q56_mul(tc, t2) / 64'((2 * n + 1) * (2 * n + 2));
			end
			bnd_sin[k] = ss;
			bnd_cos[k] = cc;
		end
	endfunction

	function automatic int octant_deg(input logic [63:0] ax, input logic [63:0] ay);
		int k;
		for (k = 0; k < TabDepth; k++)
			if (!(ay * bnd_cos[k] > ax * bnd_sin[k])) break;
		return k;
	endfunction

	function automatic void stick_polar(input int x, input int y, output logic act,
			output logic [9:0] ang, output logic [8:0] dlen);
		int ax, ay, a, d, r;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		if (x == 0 && y == 0) begin
			act = 1'b0;
			ang = '1;
			dlen = '1;
			return;
		end
		a = (ay <= ax) ? octant_deg(64'(ax), 64'(ay)) : 90 - octant_deg(64'(ay), 64'(ax));
		if (x >= 0 && y >= 0) d = a;
		else if (x < 0 && y >= 0) d = 180 - a;
		else if (x < 0) d = 180 + a;
		else d = 360 - a;
		r = 0;
		while ((r + 1) * (r + 1) <= x * x + y * y) r++;
		act = 1'b1;
		ang = 10'((d + 270) % 360);
		dlen = 9'(r > 128 ? 128 : r);
	endfunction

	function automatic int apply_zone(input int v, input logic [7:0] zone);
		return ((v < 0 ? -v : v) < int'(zone)) ? 0 : v;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		int sv;
		frame_result_t f;
		sv = int'(signed'(b));
		case (frame_pos)
			1: begin hold_lx = apply_zone(sv, ldz_reg); frame_pos = 2; end
			2: begin hold_ly = apply_zone(-sv, ldz_reg); frame_pos = 3; end
			3: begin hold_rx = apply_zone(sv, rdz_reg); frame_pos = 4; end
			4: begin hold_ry = apply_zone(-sv, rdz_reg); frame_pos = 5; end
			5: begin hold_bl = b; frame_pos = 6; end
			6: begin
				f.lx = 8'(hold_lx);
				f.ly = 9'(hold_ly);
				f.rx = 8'(hold_rx);
				f.ry = 9'(hold_ry);
				stick_polar(hold_lx, hold_ly, f.la, f.lang, f.ldist);
				stick_polar(hold_rx, hold_ry, f.ra, f.rang, f.rdist);
				f.btn = {b, hold_bl};
				frames_due.push_back(f);
				frame_pos = 0;
			end
			default: frame_pos = (b == hdr_reg) ? 1 : 0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// result checker: sampled at the falling edge, accepted at the next rising edge
	always @(negedge clk) begin
		frame_result_t f;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				errors++;
				$display("unexpected result item at %0t", $realtime);
			end else begin
				f = frames_due.pop_front();
				if (left_x !== f.lx) report_mismatch("left_x", 16'(left_x), 16'(f.lx));
				if (left_y !== f.ly) report_mismatch("left_y", 16'(left_y), 16'(f.ly));
				if (right_x !== f.rx) report_mismatch("right_x", 16'(right_x), 16'(f.rx));
				if (right_y !== f.ry) report_mismatch("right_y", 16'(right_y), 16'(f.ry));
				if (left_active !== f.la)
					report_mismatch("left_active", 16'(left_active), 16'(f.la));
				if (left_angle !== f.lang)
					report_mismatch("left_angle", 16'(left_angle), 16'(f.lang));
				if (left_distance !== f.ldist)
					report_mismatch("left_distance", 16'(left_distance), 16'(f.ldist));
				if (right_active !== f.ra)
					report_mismatch("right_active", 16'(right_active), 16'(f.ra));
				if (right_angle !== f.rang)
					report_mismatch("right_angle", 16'(right_angle), 16'(f.rang));
				if (right_distance !== f.rdist)
					report_mismatch("right_distance", 16'(right_distance), 16'(f.rdist));
				if (buttons !== f.btn) report_mismatch("buttons", buttons, f.btn);
			end
		end
	end

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len <= hold_len - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		logic ok;
		in_valid <= 1'b1;
		data_byte <= b;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		absorb_byte(b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] lx, ly, rx, ry, bl, bh);
		send_byte(hdr_reg);
		send_byte(lx);
		send_byte(ly);
		send_byte(rx);
		send_byte(ry);
		send_byte(bl);
		send_byte(bh);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (frames_due.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HEADER: hdr_reg = val;
			REG_LEFT_DZ: ldz_reg = val;
			REG_RIGHT_DZ: rdz_reg = val;
			default: ;
		endcase
	endtask

	task automatic test_directed_frames();
		send_byte(8'h5a);
		send_frame(8'h80, 8'h80, 8'h7f, 8'h7f, 8'hff, 8'hff);
		send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		// nearly along +x with a slight downward tilt: the angle wraps round to 270
		send_frame(8'h7f, 8'h01, 8'h01, 8'h00, 8'ha5, 8'h5a);
		// header value inside a frame is plain data
		send_frame(hdr_reg, hdr_reg, 8'hf0, 8'h30, hdr_reg, hdr_reg);
		drain();
	endtask

	task automatic test_dead_zones();
		write_reg(REG_HEADER, 8'hff);
		write_reg(REG_LEFT_DZ, 8'd255);
		write_reg(REG_RIGHT_DZ, 8'd10);
		write_reg(REG_UNUSED, 8'h33);
		send_frame(8'h80, 8'h7f, 8'h09, 8'hf6, 8'h12, 8'h34);
		// dead zone changed between axis bytes
		send_byte(hdr_reg);
		send_byte(8'h20);
		drain();
		write_reg(REG_LEFT_DZ, 8'd0);
		write_reg(REG_RIGHT_DZ, 8'd128);
		send_byte(8'h20);
		send_byte(8'h80);
		send_byte(8'h81);
		send_byte(8'h01);
		send_byte(8'h02);
		drain();
	endtask

	task automatic test_random(input int nframes);
		for (int i = 0; i < nframes; i++) begin
			if ($urandom_range(99) < 15) send_byte(8'($urandom));
			if ($urandom_range(99) < 10) begin
				send_byte(hdr_reg);
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else begin
				send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom));
			end
		end
		drain();
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_len = 400;
		@(posedge clk);
		for (int i = 0; i < 4; i++)
			send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
		drain();
	endtask

	task automatic new_settings();
		write_reg(REG_HEADER, 8'($urandom));
		write_reg(REG_LEFT_DZ, 8'($urandom_range(0, 40)));
		write_reg(REG_RIGHT_DZ, 8'($urandom_range(0, 40)));
	endtask

	initial begin
		build_boundaries();
		hdr_reg = '0;
		ldz_reg = '0;
		rdz_reg = '0;
		frame_pos = 0;
		hold_lx = 0;
		hold_ly = 0;
		hold_rx = 0;
		hold_ry = 0;
		hold_bl = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_frames();
		test_dead_zones();
		send_idle = 37;
		recv_idle = 63;
		new_settings();
		test_random(28);
		send_idle = 63;
		recv_idle = 37;
		new_settings();
		test_random(28);
		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_LEFT_DZ, 8'd0);
		write_reg(REG_RIGHT_DZ, 8'd0);
		test_random(28);
		test_backpressure();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule
